/* rtl/core/wsd_pkg.sv */
// shared types and constants of the websocket deframer
// no dependencies; imported by every module of the block
`default_nettype none

package wsd_pkg;

  localparam logic [7:0] FIN_BIT      = 8'h80;
  localparam logic [7:0] MASK_BIT     = 8'h80;
  localparam logic [7:0] OPCODE_MASK  = 8'h0F;
  localparam logic [7:0] LEN7_MASK    = 8'h7F;
  localparam logic [6:0] LEN7_EXT16   = 7'd126;
  localparam logic [6:0] LEN7_EXT64   = 7'd127;
  localparam logic [3:0] EXT16_BYTES  = 4'd2;
  localparam logic [3:0] EXT64_BYTES  = 4'd8;
  localparam logic [2:0] KEY_BYTES    = 3'd4;

  // one classified word between parser and output stage
  typedef struct packed {
    logic [7:0] data_byte;
    logic [7:0] key_byte;
    logic [3:0] frame_opcode;
    logic       final_flag;
    logic       has_data;
    logic       is_last;
    logic       rejected;
  } wsd_entry_t;

endpackage

`default_nettype wire

/* rtl/core/wsd_front.sv */
// header parser: takes received bytes and classifies them into entries
// depends on wsd_pkg
`default_nettype none

module wsd_front
  import wsd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       byte_valid_i,
  input  wire logic [7:0] byte_i,
  output logic            push_o,
  output wsd_entry_t      entry_o
);

  typedef enum logic [2:0] {
    PH_HDR0    = 3'd0,
    PH_HDR1    = 3'd1,
    PH_EXTLEN  = 3'd2,
    PH_KEY     = 3'd3,
    PH_PAYLOAD = 3'd4
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [2:0]  fc_r, fc_nxt;
  logic        kind_r, kind_nxt;
  logic [63:0] rem_r, rem_nxt;
  logic [3:0]  opc_r, opc_nxt;
  logic        fin_r, fin_nxt;
  logic        men_r, men_nxt;
  logic [31:0] key_r, key_nxt;
  logic [1:0]  mp_r, mp_nxt;

  logic [6:0]  len7;
  logic [2:0]  fc_inc;
  logic [3:0]  fc_cnt;
  logic [63:0] rem_shift;
  logic [7:0]  key_sel;
  logic        rejected;

  assign len7      = 7'(byte_i & LEN7_MASK);
  assign fc_inc    = fc_r + 3'd1;
  assign fc_cnt    = (fc_inc == 3'd0) ? 4'd8 : {1'b0, fc_inc};
  assign rem_shift = {rem_r[55:0], byte_i};
  assign rejected  = !fin_r && (opc_r != 4'd0);

  always_comb begin
    unique case (mp_r)
      2'd0:    key_sel = key_r[31:24];
      2'd1:    key_sel = key_r[23:16];
      2'd2:    key_sel = key_r[15:8];
      default: key_sel = key_r[7:0];
    endcase
  end

  always_comb begin
    phase_nxt = phase_r;
    fc_nxt    = fc_r;
    kind_nxt  = kind_r;
    rem_nxt   = rem_r;
    opc_nxt   = opc_r;
    fin_nxt   = fin_r;
    men_nxt   = men_r;
    key_nxt   = key_r;
    mp_nxt    = mp_r;
    push_o    = 1'b0;
    // empty-frame marker unless overwritten by a payload byte
    entry_o.data_byte    = 8'd0;
    entry_o.key_byte     = 8'd0;
    entry_o.frame_opcode = opc_r;
    entry_o.final_flag   = fin_r;
    entry_o.has_data     = 1'b0;
    entry_o.is_last      = 1'b1;
    entry_o.rejected     = rejected;
    if (byte_valid_i) begin
      unique case (phase_r)
        PH_HDR1: begin
          men_nxt = (byte_i & MASK_BIT) != 8'd0;
          key_nxt = 32'd0;
          fc_nxt  = 3'd0;
          if (len7 == LEN7_EXT16 || len7 == LEN7_EXT64) begin
            kind_nxt  = (len7 == LEN7_EXT64);
            rem_nxt   = 64'd0;
            phase_nxt = PH_EXTLEN;
          end else begin
            rem_nxt = {57'd0, len7};
            mp_nxt  = 2'd0;
            if ((byte_i & MASK_BIT) != 8'd0) begin
              phase_nxt = PH_KEY;
            end else if (len7 == 7'd0) begin
              phase_nxt = PH_HDR0;
              push_o    = 1'b1;
            end else begin
              phase_nxt = PH_PAYLOAD;
            end
          end
        end
        PH_EXTLEN: begin
          rem_nxt = rem_shift;
          fc_nxt  = fc_inc;
          if (fc_cnt >= (kind_r ? EXT64_BYTES : EXT16_BYTES)) begin
            fc_nxt = 3'd0;
            mp_nxt = 2'd0;
            if (men_r) begin
              phase_nxt = PH_KEY;
            end else if (rem_shift == 64'd0) begin
              phase_nxt = PH_HDR0;
              push_o    = 1'b1;
            end else begin
              phase_nxt = PH_PAYLOAD;
            end
          end
        end
        PH_KEY: begin
          key_nxt = {key_r[23:0], byte_i};
          fc_nxt  = fc_inc;
          if (fc_inc >= KEY_BYTES) begin
            fc_nxt = 3'd0;
            mp_nxt = 2'd0;
            if (rem_r == 64'd0) begin
              phase_nxt = PH_HDR0;
              push_o    = 1'b1;
            end else begin
              phase_nxt = PH_PAYLOAD;
            end
          end
        end
        PH_PAYLOAD: begin
          mp_nxt  = mp_r + 2'd1;
          rem_nxt = rem_r - 64'd1;
          push_o  = 1'b1;
          entry_o.data_byte = byte_i;
          entry_o.key_byte  = men_r ? key_sel : 8'd0;
          entry_o.has_data  = 1'b1;
          entry_o.is_last   = (rem_r == 64'd1);
          if (rem_r == 64'd1) begin
            phase_nxt = PH_HDR0;
          end
        end
        default: begin
          // first header byte, also taken for any phase code with no meaning
          fin_nxt   = (byte_i & FIN_BIT) != 8'd0;
          opc_nxt   = 4'(byte_i & OPCODE_MASK);
          phase_nxt = PH_HDR1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HDR0;
      fc_r    <= 3'd0;
      kind_r  <= 1'b0;
      rem_r   <= 64'd0;
      opc_r   <= 4'd0;
      fin_r   <= 1'b0;
      men_r   <= 1'b0;
      key_r   <= 32'd0;
      mp_r    <= 2'd0;
    end else begin
      phase_r <= phase_nxt;
      fc_r    <= fc_nxt;
      kind_r  <= kind_nxt;
      rem_r   <= rem_nxt;
      opc_r   <= opc_nxt;
      fin_r   <= fin_nxt;
      men_r   <= men_nxt;
      key_r   <= key_nxt;
      mp_r    <= mp_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/wsd_fifo.sv */
// short entry queue between parser and output stage
// depends on wsd_pkg
`default_nettype none

module wsd_fifo
  import wsd_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push_i,
  input  wsd_entry_t entry_i,
  input  wire logic  pop_i,
  output wsd_entry_t entry_o,
  output logic       full_o,
  output logic       empty_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  wsd_entry_t       mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full_o  = (cnt_r == CNT_W'(DEPTH));
  assign empty_o = (cnt_r == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign entry_o = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= entry_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/wsd_back.sv */
// output stage: unmasks queued entries into the result register
// depends on wsd_pkg
`default_nettype none

module wsd_back
  import wsd_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wsd_entry_t entry_i,
  input  wire logic  q_empty_i,
  output logic       q_pop_o,
  input  wire logic  out_pop,
  output logic       out_empty,
  output wsd_entry_t out_o
);

  logic       valid_r, valid_nxt;
  wsd_entry_t res_r;
  wsd_entry_t unmasked;

  // refill when the register is free or its word leaves this cycle
  assign q_pop_o   = !q_empty_i && (!valid_r || out_pop);
  assign out_empty = !valid_r;
  assign out_o     = res_r;

  always_comb begin
    unmasked           = entry_i;
    unmasked.data_byte = entry_i.data_byte ^ entry_i.key_byte;
    unmasked.key_byte  = 8'd0;
  end

  always_comb begin
    valid_nxt = valid_r;
    if (q_pop_o) begin
      valid_nxt = 1'b1;
    end else if (out_pop) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop_o) begin
      res_r <= unmasked;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/websocket_frame_deframer_unit.sv */
// websocket frame deframer, top level
// depends on wsd_pkg, wsd_front, wsd_fifo and wsd_back
//
// input: one received byte per word on in_rx_byte, taken when in_push is high
// and in_full low. output: one result word per payload byte (unmasked data,
// opcode, fin, has_data, is_last, rejected), or one marker word with has_data
// low for a zero-length frame; the oldest word sits on the out_ ports while
// out_empty is low and leaves when out_pop is high.
// header, extended length and key bytes give no word.
// throughput: one byte per cycle while in_full is low.
// a result is written into the queue at the edge that takes its byte and
// moves to the output register once that register is free or its word leaves.
// a stalled receiver fills the FIFO_DEPTH-entry queue and the result
// register; in_full then rises until a word is popped.
// reset (rst_n low, synchronous): parser waits for the first header byte,
// queue and result register are emptied.
`default_nettype none

module websocket_frame_deframer_unit
  import wsd_pkg::*;
#(
  parameter int FIFO_DEPTH = 4
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_push,
  input  wire logic [7:0] in_rx_byte,
  output logic            in_full,
  input  wire logic       out_pop,
  output logic            out_empty,
  output logic [7:0]      out_data_byte,
  output logic [3:0]      out_frame_opcode,
  output logic            out_final_flag,
  output logic            out_has_data,
  output logic            out_is_last,
  output logic            out_rejected
);

  logic       accept;
  logic       fr_push;
  wsd_entry_t fr_entry;
  wsd_entry_t q_entry;
  logic       q_empty;
  logic       q_pop;
  wsd_entry_t res;

  // a byte is parsed only when the queue can take any word it makes
  assign accept = in_push && !in_full;

  wsd_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .byte_valid_i (accept),
    .byte_i       (in_rx_byte),
    .push_o       (fr_push),
    .entry_o      (fr_entry)
  );

  wsd_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (fr_push),
    .entry_i (fr_entry),
    .pop_i   (q_pop),
    .entry_o (q_entry),
    .full_o  (in_full),
    .empty_o (q_empty)
  );

  // unmask and hold the word the receiver sees
  wsd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .entry_i   (q_entry),
    .q_empty_i (q_empty),
    .q_pop_o   (q_pop),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_o     (res)
  );

  assign out_data_byte    = res.data_byte;
  assign out_frame_opcode = res.frame_opcode;
  assign out_final_flag   = res.final_flag;
  assign out_has_data     = res.has_data;
  assign out_is_last      = res.is_last;
  assign out_rejected     = res.rejected;

endmodule

`default_nettype wire
